FILE: design/gsms_pkg.sv
// Package for the gas sensor measure sequencer.
// Holds op, kind and phase codes, size defaults, result and config types.
// No dependencies.
package gsms_pkg;

  // Default sizes
  localparam int BASELINE_SAMPLES_DEF = 8;
  localparam int MEASURE_SAMPLES_DEF  = 8;
  localparam int SAMPLE_BITS_DEF      = 12;

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 12;
  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 12;
  localparam int IVAL_W   = 16;
  // widest baseline sum (12-bit samples, 16 of them)
  localparam int VAL_W    = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Config port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_BASE_IVAL = 2'd0;
  localparam logic [1:0] REG_MEAS_IVAL = 2'd1;
  localparam logic [1:0] REG_WARN_TIME = 2'd2;
  localparam logic [IVAL_W-1:0] BASE_IVAL_RST = 16'd500;
  localparam logic [IVAL_W-1:0] MEAS_IVAL_RST = 16'd500;
  localparam logic [IVAL_W-1:0] WARN_TIME_RST = 16'd1000;

  // Op codes
  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_START_COMB = 3'd1;
  localparam logic [OP_W-1:0] OP_START_BASE = 3'd2;
  localparam logic [OP_W-1:0] OP_START_MEAS = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL     = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BUSY       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_BASE_START = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MEAS_ARMED = 4'd2;
  localparam logic [KIND_W-1:0] KIND_BASE_VALUE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_BASE_DONE  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_MEAS_BEGIN = 4'd5;
  localparam logic [KIND_W-1:0] KIND_MEAS_SMP   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MEAS_END   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_SESS_END   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_CANCELLED  = 4'd9;

  // Sequencer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BASE = 2'd1;
  localparam logic [1:0] PH_WARN = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  // One result; val holds the raw baseline sum for KIND_BASE_VALUE
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  val;
    logic              comb;
  } res_t;

  // All results caused by one request
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
    logic           buzzer;
  } bundle_t;

  // Interval settings handed to the front
  typedef struct packed {
    logic [IVAL_W-1:0] base_ival;
    logic [IVAL_W-1:0] meas_ival;
    logic [IVAL_W-1:0] warn_time;
  } cfg_t;

endpackage

FILE: design/gsms_front.sv
// Front end: accepts requests, runs the phase sequencer and builds result bundles.
// Depends on gsms_pkg.
module gsms_front import gsms_pkg::*; #(
  parameter int BASELINE_SAMPLES = BASELINE_SAMPLES_DEF,
  parameter int MEASURE_SAMPLES  = MEASURE_SAMPLES_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [OP_W-1:0]     op,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output logic                push,
  output bundle_t             bundle
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(BASELINE_SAMPLES);
  localparam int CNT_MAX = (BASELINE_SAMPLES > MEASURE_SAMPLES) ?
                           BASELINE_SAMPLES : MEASURE_SAMPLES;
  localparam int CNT_W = $clog2(CNT_MAX + 2);

  logic [1:0]        phase, phase_next;
  logic              comb, comb_next;
  logic [CNT_W-1:0]  cnt, cnt_next, cnt_inc;
  logic [SUM_W-1:0]  sum, sum_next, sum_add;
  logic [TIME_W-1:0] mark, mark_next;
  logic              buzz, buzz_next;

  logic [SAMPLE_BITS-1:0] smp;
  logic [TIME_W-1:0]      elapsed;
  logic                   base_due, warn_due, meas_due;

  assign smp     = sample[SAMPLE_BITS-1:0];
  assign elapsed = now_ms - mark;
  assign cnt_inc = cnt + CNT_W'(1);
  assign sum_add = sum + SUM_W'(smp);

  assign base_due = elapsed >= TIME_W'(cfg.base_ival);
  assign warn_due = elapsed >= TIME_W'(cfg.warn_time);
  assign meas_due = elapsed >= TIME_W'(cfg.meas_ival);

  // Next state and results of the current request
  always_comb begin
    phase_next = phase;
    comb_next  = comb;
    cnt_next   = cnt;
    sum_next   = sum;
    mark_next  = mark;
    buzz_next  = buzz;
    bundle     = '0;

    unique case (op)
      OP_TICK: begin
        if (phase == PH_BASE && base_due) begin
          sum_next  = sum_add;
          cnt_next  = cnt_inc;
          mark_next = now_ms;
          if (cnt_inc >= CNT_W'(BASELINE_SAMPLES)) begin
            bundle.res[0] = '{kind: KIND_BASE_VALUE, val: VAL_W'(sum_add), comb: comb};
            if (comb) begin
              phase_next = PH_WARN;
              buzz_next  = 1'b1;
              bundle.cnt = 2'd1;
            end else begin
              bundle.res[1] = '{kind: KIND_BASE_DONE, val: '0, comb: comb};
              bundle.cnt    = 2'd2;
              phase_next    = PH_IDLE;
              comb_next     = 1'b0;
              cnt_next      = '0;
              sum_next      = '0;
            end
          end
        end else if (phase == PH_WARN && warn_due) begin
          buzz_next     = 1'b0;
          phase_next    = PH_MEAS;
          cnt_next      = CNT_W'(1);
          mark_next     = now_ms;
          bundle.res[0] = '{kind: KIND_MEAS_BEGIN, val: '0, comb: comb};
          bundle.res[1] = '{kind: KIND_MEAS_SMP, val: VAL_W'(smp), comb: comb};
          bundle.cnt    = 2'd2;
        end else if (phase == PH_MEAS && meas_due) begin
          bundle.res[0] = '{kind: KIND_MEAS_SMP, val: VAL_W'(smp), comb: comb};
          bundle.cnt    = 2'd1;
          cnt_next      = cnt_inc;
          mark_next     = now_ms;
          if (cnt_inc >= CNT_W'(MEASURE_SAMPLES)) begin
            bundle.res[1] = '{kind: KIND_MEAS_END, val: '0, comb: comb};
            bundle.res[2] = '{kind: KIND_SESS_END, val: '0, comb: comb};
            bundle.cnt    = 2'd3;
            phase_next    = PH_IDLE;
            comb_next     = 1'b0;
            cnt_next      = '0;
            sum_next      = '0;
          end
        end
      end
      OP_START_COMB, OP_START_BASE: begin
        bundle.cnt = 2'd1;
        if (phase != PH_IDLE) begin
          bundle.res[0] = '{kind: KIND_BUSY, val: '0, comb: comb};
        end else begin
          comb_next     = (op == OP_START_COMB);
          sum_next      = SUM_W'(smp);
          cnt_next      = CNT_W'(1);
          mark_next     = now_ms;
          phase_next    = PH_BASE;
          bundle.res[0] = '{kind: KIND_BASE_START, val: '0, comb: (op == OP_START_COMB)};
        end
      end
      OP_START_MEAS: begin
        bundle.cnt = 2'd1;
        if (phase != PH_IDLE) begin
          bundle.res[0] = '{kind: KIND_BUSY, val: '0, comb: comb};
        end else begin
          comb_next     = 1'b0;
          phase_next    = PH_WARN;
          mark_next     = now_ms;
          buzz_next     = 1'b1;
          bundle.res[0] = '{kind: KIND_MEAS_ARMED, val: '0, comb: 1'b0};
        end
      end
      OP_CANCEL: begin
        bundle.cnt    = 2'd1;
        bundle.res[0] = '{kind: KIND_CANCELLED, val: '0, comb: comb};
        phase_next    = PH_IDLE;
        comb_next     = 1'b0;
        cnt_next      = '0;
        sum_next      = '0;
        buzz_next     = 1'b0;
      end
      default: begin
        // unused op codes: no effect
      end
    endcase

    bundle.buzzer = buzz_next;
  end

  assign push = accept && (bundle.cnt != 2'd0);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      comb  <= 1'b0;
      cnt   <= '0;
      sum   <= '0;
      mark  <= '0;
      buzz  <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      comb  <= comb_next;
      cnt   <= cnt_next;
      sum   <= sum_next;
      mark  <= mark_next;
      buzz  <= buzz_next;
    end
  end

endmodule

FILE: design/gsms_queue.sv
// Short FIFO of result bundles between front and back.
// Depends on gsms_pkg.
module gsms_queue import gsms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/gsms_back.sv
// Back end: takes bundles from the queue and sends their results one per cycle
// unless stalled. Finishes the baseline average here. Depends on gsms_pkg.
module gsms_back import gsms_pkg::*; #(
  parameter int BASELINE_SAMPLES = BASELINE_SAMPLES_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bundle_t            head,
  input  logic               empty,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [KIND_W-1:0]  kind,
  output logic [VALUE_W-1:0] value,
  output logic               combined_session,
  output logic               buzzer_on,
  output logic               last
);

  localparam int SUM_W     = SAMPLE_BITS + $clog2(BASELINE_SAMPLES);
  localparam int DIV_SHIFT = SUM_W + $clog2(BASELINE_SAMPLES);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + BASELINE_SAMPLES - 1) / BASELINE_SAMPLES;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;

  logic [1:0]         idx;
  logic               load, take, at_last;
  res_t               cur;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] val_sel;

  assign load    = !result_valid || !result_stall;
  assign take    = load && !empty;
  assign cur     = head.res[idx];
  assign at_last = (idx == head.cnt - 2'd1);
  assign pop     = take && at_last;

  // Average by reciprocal multiply; the baseline value is always first
  assign prod = PROD_W'(head.res[0].val[SUM_W-1:0]) * PROD_W'(DIV_SHIFT'(DIV_MULT));

  always_comb begin
    if (cur.kind == KIND_BASE_VALUE) begin
      val_sel = VALUE_W'(prod[DIV_SHIFT +: SAMPLE_BITS]);
    end else begin
      val_sel = VALUE_W'(cur.val[SAMPLE_BITS-1:0]);
    end
  end

  // Result index within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind             <= cur.kind;
      value            <= val_sel;
      combined_session <= cur.comb;
      buzzer_on        <= head.buzzer;
      last             <= at_last;
    end
  end

endmodule

FILE: design/gas_sensor_measure_sequencer.sv
// Gas sensor measure sequencer, top level: config registers, front, queue, back.
// The first result of a request passes through the bundle queue and then the output register,
// which it reaches without waiting when the queue and output register are empty.
// Throughput: a request is taken each cycle while the two-entry bundle queue has
// room; the output sends one result per cycle while result_stall is low, and a
// request yields 0 to 3 results.
// Reset (rst, synchronous): idle phase, buzzer off, queue empty, intervals 500/500/1000.
module gas_sensor_measure_sequencer import gsms_pkg::*; #(
  parameter int BASELINE_SAMPLES = BASELINE_SAMPLES_DEF,
  parameter int MEASURE_SAMPLES  = MEASURE_SAMPLES_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // request channel
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [SAMPLE_W-1:0] sample,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [KIND_W-1:0]   kind,
  output logic [VALUE_W-1:0]  value,
  output logic                combined_session,
  output logic                buzzer_on,
  output logic                last
);

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       accept, push, pop, q_empty, q_full;
  bundle_t    push_data, head;

  // Config registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_ival <= BASE_IVAL_RST;
      cfg.meas_ival <= MEAS_IVAL_RST;
      cfg.warn_time <= WARN_TIME_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BASE_IVAL: cfg.base_ival <= pwdata[IVAL_W-1:0];
        REG_MEAS_IVAL: cfg.meas_ival <= pwdata[IVAL_W-1:0];
        REG_WARN_TIME: cfg.warn_time <= pwdata[IVAL_W-1:0];
        default: begin
          // no register here
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_IVAL: prdata = DATA_W'(cfg.base_ival);
      REG_MEAS_IVAL: prdata = DATA_W'(cfg.meas_ival);
      REG_WARN_TIME: prdata = DATA_W'(cfg.warn_time);
      default:       prdata = '0;
    endcase
  end

  // Request handshake
  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  gsms_front #(
    .BASELINE_SAMPLES (BASELINE_SAMPLES),
    .MEASURE_SAMPLES  (MEASURE_SAMPLES),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op),
    .now_ms (now_ms),
    .sample (sample),
    .cfg    (cfg),
    .push   (push),
    .bundle (push_data)
  );

  gsms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  gsms_back #(
    .BASELINE_SAMPLES (BASELINE_SAMPLES),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (q_empty),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .kind             (kind),
    .value            (value),
    .combined_session (combined_session),
    .buzzer_on        (buzzer_on),
    .last             (last)
  );

endmodule

FILE: dv/gas_sensor_measure_sequencer_test.sv
// Testbench for gas_sensor_measure_sequencer: directed and random request streams with
// a built-in sequencer predictor, random idling, output hold-off and interval changes.
// Depends on gsms_pkg and the gas_sensor_measure_sequencer RTL.
module gas_sensor_measure_sequencer_test import gsms_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // op codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // cycles for in-flight requests with no result to clear the pipe
  localparam int SETTLE = 10;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               comb;
    logic               buzzer;
    logic               last;
  } seq_result_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                item_valid;
  logic                item_stall;
  logic [OP_W-1:0]     op;
  logic [TIME_W-1:0]   now_ms;
  logic [SAMPLE_W-1:0] sample;
  logic                result_valid;
  logic                result_stall;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  value;
  logic                combined_session;
  logic                buzzer_on;
  logic                last;

  // predictor state and interval copies
  logic [1:0]          ph;
  logic                comb_f;
  logic [4:0]          smp_cnt;
  logic [15:0]         smp_sum;
  logic [TIME_W-1:0]   mark_ms;
  logic                buzz;
  logic [IVAL_W-1:0]   base_iv;
  logic [IVAL_W-1:0]   meas_iv;
  logic [IVAL_W-1:0]   warn_t;

  seq_result_t         pending_results[$];
  seq_result_t         step_res[3];
  int                  step_n;
  seq_result_t         head;

  logic [TIME_W-1:0]   cur_ms;
  int                  items_sent;
  int                  errors;
  int                  quiet_cycles;
  int                  hold_left;
  int                  stall_run;
  bit                  jitter_on;

  gas_sensor_measure_sequencer u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .op               (op),
    .now_ms           (now_ms),
    .sample           (sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .kind             (kind),
    .value            (value),
    .combined_session (combined_session),
    .buzzer_on        (buzzer_on),
    .last             (last)
  );

  always #1ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // record one result; combined flag is taken before any clearing
  task automatic add_result(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    step_res[step_n].kind  = k;
    step_res[step_n].value = v;
    step_res[step_n].comb  = comb_f;
    step_n++;
  endtask

  task automatic clear_session();
    ph      = PH_IDLE;
    comb_f  = 1'b0;
    smp_cnt = '0;
    smp_sum = '0;
  endtask

  // advance the sequencer copy by one request and queue what it reports
  task automatic sequencer_step(input logic [OP_W-1:0] o, input logic [TIME_W-1:0] t,
                                input logic [SAMPLE_W-1:0] s);
    logic [TIME_W-1:0] elapsed;
    elapsed = t - mark_ms;
    step_n = 0;
    case (o)
      OP_TICK: begin
        if (ph == PH_BASE && elapsed >= TIME_W'(base_iv)) begin
          smp_sum = smp_sum + 16'(s);
          smp_cnt = smp_cnt + 5'd1;
          mark_ms = t;
          if (smp_cnt >= 5'(BASELINE_SAMPLES_DEF)) begin
            add_result(KIND_BASE_VALUE, VALUE_W'(smp_sum / BASELINE_SAMPLES_DEF));
            if (comb_f) begin
              ph   = PH_WARN;
              buzz = 1'b1;
            end else begin
              add_result(KIND_BASE_DONE, '0);
              clear_session();
            end
          end
        end else if (ph == PH_WARN && elapsed >= TIME_W'(warn_t)) begin
          buzz = 1'b0;
          add_result(KIND_MEAS_BEGIN, '0);
          ph      = PH_MEAS;
          smp_cnt = 5'd1;
          mark_ms = t;
          add_result(KIND_MEAS_SMP, s);
        end else if (ph == PH_MEAS && elapsed >= TIME_W'(meas_iv)) begin
          add_result(KIND_MEAS_SMP, s);
          smp_cnt = smp_cnt + 5'd1;
          mark_ms = t;
          if (smp_cnt >= 5'(MEASURE_SAMPLES_DEF)) begin
            add_result(KIND_MEAS_END, '0);
            add_result(KIND_SESS_END, '0);
            clear_session();
          end
        end
      end
      OP_START_COMB, OP_START_BASE: begin
        if (ph != PH_IDLE) begin
          add_result(KIND_BUSY, '0);
        end else begin
          comb_f  = (o == OP_START_COMB);
          smp_sum = 16'(s);
          smp_cnt = 5'd1;
          mark_ms = t;
          ph      = PH_BASE;
          add_result(KIND_BASE_START, '0);
        end
      end
      OP_START_MEAS: begin
        if (ph != PH_IDLE) begin
          add_result(KIND_BUSY, '0);
        end else begin
          comb_f  = 1'b0;
          ph      = PH_WARN;
          mark_ms = t;
          buzz    = 1'b1;
          add_result(KIND_MEAS_ARMED, '0);
        end
      end
      OP_CANCEL: begin
        add_result(KIND_CANCELLED, '0);
        clear_session();
        buzz = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < step_n; i++) begin
      step_res[i].buzzer = buzz;
      step_res[i].last   = (i == step_n - 1);
      pending_results.push_back(step_res[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // offer one request and wait for it to be taken
  task automatic send_req(input logic [OP_W-1:0] o, input logic [TIME_W-1:0] t,
                          input logic [SAMPLE_W-1:0] s);
    int n;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      @(negedge clk);
      item_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid = 1'b1;
    op         = o;
    now_ms     = t;
    sample     = s;
    do @(posedge clk); while (item_stall);
    sequencer_step(o, t, s);
    if (o <= OP_CANCEL) items_sent++;
  endtask

  // time step for a tick, aimed at the interval of the current phase
  function automatic logic [TIME_W-1:0] tick_gap();
    logic [TIME_W-1:0] iv;
    case (ph)
      PH_BASE: iv = TIME_W'(base_iv);
      PH_WARN: iv = TIME_W'(warn_t);
      PH_MEAS: iv = TIME_W'(meas_iv);
      default: iv = TIME_W'($urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return TIME_W'($urandom);
      2, 3:    return iv - 1;
      default: return iv + TIME_W'($urandom_range(0, 2));
    endcase
  endfunction

  // move the clock on, pick a sample and send
  task automatic issue(input logic [OP_W-1:0] o);
    logic [SAMPLE_W-1:0] s;
    if (o == OP_TICK) cur_ms = cur_ms + tick_gap();
    else cur_ms = cur_ms + TIME_W'($urandom_range(0, 50));
    if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 1) ? '1 : '0;
    else s = SAMPLE_W'($urandom_range(0, 4095));
    send_req(o, cur_ms, s);
  endtask

  // drop valid, then wait for every expected result and the pipe to clear
  task automatic wait_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [IVAL_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_BASE_IVAL: base_iv = v;
      REG_MEAS_IVAL: meas_iv = v;
      REG_WARN_TIME: warn_t  = v;
      default: ;
    endcase
  endtask

  task automatic set_intervals(input logic [IVAL_W-1:0] b, input logic [IVAL_W-1:0] m,
                               input logic [IVAL_W-1:0] w);
    wait_drained();
    apb_write(REG_BASE_IVAL, b);
    apb_write(REG_MEAS_IVAL, m);
    apb_write(REG_WARN_TIME, w);
  endtask

  // one session: a start (or idle noise), then mostly ticks until idle or the guard ends
  task automatic run_session();
    int r;
    int guard;
    logic [OP_W-1:0] o;
    r = $urandom_range(0, 19);
    if (r < 8) o = OP_START_COMB;
    else if (r < 12) o = OP_START_BASE;
    else if (r < 17) o = OP_START_MEAS;
    else if (r < 19) o = OP_CANCEL;
    else o = OP_TICK;
    issue(o);
    guard = 0;
    while (ph != PH_IDLE && guard < 60) begin
      r = $urandom_range(0, 39);
      if (r == 0) o = OP_CANCEL;
      else if (r == 1) o = OP_START_COMB + OP_W'($urandom_range(0, 2));
      else if (r == 2) o = OP_RSVD_FIRST + OP_W'($urandom_range(0, 2));
      else o = OP_TICK;
      issue(o);
      guard++;
    end
  endtask

  task automatic run_items(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) run_session();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset intervals; full combined baseline across the time wrap, busy starts,
  // ignored op, cancel in measure and in warning, cancel while idle
  task automatic test_directed();
    jitter_on = 1'b1;
    cur_ms = 32'hFFFF_FE00;
    send_req(OP_CANCEL, cur_ms, 12'h000);
    send_req(OP_START_COMB, cur_ms, 12'hFFF);
    send_req(OP_START_BASE, cur_ms, 12'h000);
    cur_ms = cur_ms + TIME_W'(base_iv) - 1;
    send_req(OP_TICK, cur_ms, 12'hFFF);
    repeat (BASELINE_SAMPLES_DEF - 1) begin
      cur_ms = cur_ms + TIME_W'(base_iv);
      send_req(OP_TICK, cur_ms, 12'hFFF);
    end
    send_req(OP_RSVD_LAST, cur_ms, 12'hFFF);
    send_req(OP_START_MEAS, cur_ms, 12'hAAA);
    cur_ms = cur_ms + TIME_W'(warn_t);
    send_req(OP_TICK, cur_ms, 12'h000);
    send_req(OP_CANCEL, cur_ms, 12'h555);
    send_req(OP_START_MEAS, cur_ms, 12'h000);
    send_req(OP_CANCEL, cur_ms, 12'hFFF);
  endtask

  task automatic test_fast_intervals();
    set_intervals(16'd1, 16'd1, 16'd1);
    jitter_on = 1'b1;
    run_items(80);
  endtask

  task automatic test_slow_intervals();
    set_intervals(16'hFFFF, 16'hFFFF, 16'hFFFF);
    jitter_on = 1'b1;
    cur_ms = 32'hFFF0_0000;
    run_items(80);
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_intervals(BASE_IVAL_RST, MEAS_IVAL_RST, WARN_TIME_RST);
    jitter_on = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      issue(OP_START_COMB);
      issue(OP_CANCEL);
    end
    wait_drained();
  endtask

  task automatic test_random_config();
    logic [IVAL_W-1:0] iv[3];
    repeat (3) begin
      foreach (iv[i]) begin
        if ($urandom_range(0, 1)) iv[i] = IVAL_W'($urandom_range(1, 8));
        else iv[i] = IVAL_W'($urandom_range(1, 65535));
      end
      set_intervals(iv[0], iv[1], iv[2]);
      jitter_on = ($urandom_range(0, 3) != 0);
      run_items(50);
    end
  endtask

  // no idling on either side
  task automatic test_quiet_tail();
    set_intervals(IVAL_W'($urandom_range(1, 20)), IVAL_W'($urandom_range(1, 20)),
                  IVAL_W'($urandom_range(1, 20)));
    jitter_on = 1'b0;
    run_items(60);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall generation, checking, watchdog
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    $display("mismatch %s: expected 0x%0h got 0x%0h", what, exp_v, got_v);
    errors++;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall = 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      result_stall = 1'b1;
      stall_run--;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      result_stall = 1'b1;
      stall_run = $urandom_range(0, 9);
    end else begin
      result_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result kind", 0, kind);
        end else begin
          head = pending_results.pop_front();
          if (kind !== head.kind) flag_mismatch("kind", head.kind, kind);
          if (value !== head.value) flag_mismatch("value", head.value, value);
          if (combined_session !== head.comb)
            flag_mismatch("combined_session", head.comb, combined_session);
          if (buzzer_on !== head.buzzer) flag_mismatch("buzzer_on", head.buzzer, buzzer_on);
          if (last !== head.last) flag_mismatch("last", head.last, last);
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL gas_sensor_measure_sequencer");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    item_valid   = 1'b0;
    op           = OP_TICK;
    now_ms       = '0;
    sample       = '0;
    result_stall = 1'b0;
    errors       = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    stall_run    = 0;
    jitter_on    = 1'b0;
    cur_ms       = '0;
    base_iv      = BASE_IVAL_RST;
    meas_iv      = MEAS_IVAL_RST;
    warn_t       = WARN_TIME_RST;
    buzz         = 1'b0;
    mark_ms      = '0;
    clear_session();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fast_intervals();
    test_slow_intervals();
    test_backpressure();
    test_random_config();
    test_quiet_tail();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS gas_sensor_measure_sequencer");
    end else begin
      $display("FAIL gas_sensor_measure_sequencer");
    end
    $finish;
  end

endmodule
